/* sv/fnpll_pkg.sv */
package fnpll_pkg;

    // field and datapath widths
    localparam int FREQ_W    = 23;
    localparam int REF_W     = 18;
    localparam int STEP_W    = 9;
    localparam int SEL_W     = 3;
    localparam int VCO_W     = 30;
    localparam int SSTEP_W   = 16;
    localparam int DVD_W     = 30;
    localparam int DVS_W     = 23;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 18;

    // default request queue depth
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH_STEP  = 1'd1;

    // reset values of the configuration registers
    localparam logic [REF_W-1:0]  REF_RESET  = 18'd10000;
    localparam logic [STEP_W-1:0] STEP_RESET = 9'd25;

    // fixed register words and constants
    localparam logic [WORD_W-1:0] WORD_R5      = 32'h0058_0005;
    localparam logic [WORD_W-1:0] WORD_R4_BASE = 32'h0085_041C;
    localparam logic [WORD_W-1:0] WORD_R3      = 32'h0000_04B3;
    localparam logic [WORD_W-1:0] WORD_R2      = 32'h1800_4EC2;
    localparam logic [WORD_W-1:0] WORD_R1_BASE = 32'h0800_8001;
    localparam logic [DVD_W-1:0]  VCO_TOP_KHZ  = 30'd4400000;
    localparam logic [STEP_W-1:0] STEP_DEFAULT = 9'd25;

    // request as held in the queue
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              rf_en;
    } t_req;

    // divider command and response
    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_cmd;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quot;
        logic [DVS_W-1:0]  rem;
    } t_div_rsp;

    // position of the highest set bit of a byte, 0 for 0 and 1
    function automatic logic [SEL_W-1:0] top_bit_of_byte(input logic [7:0] b);
        logic [SEL_W-1:0] pos;
        pos = '0;
        for (int i = 1; i < 8; i++) begin
            if (b[i]) begin
                pos = SEL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* sv/fnpll_front.sv */
module fnpll_front #(
    parameter int DEPTH = fnpll_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fnpll_pkg::FREQ_W-1:0]   i_center_freq,
    input  logic                           i_rf_enable,
    input  logic                           i_use_external,
    output logic                           o_req_valid,
    output fnpll_pkg::t_req                o_req,
    input  logic                           i_req_pop
);
    import fnpll_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;
    t_req             new_req;

    // external source means the internal frequency is zero
    always_comb begin
        new_req.freq  = i_use_external ? '0 : i_center_freq;
        new_req.rf_en = i_rf_enable;
    end

    assign s_axis_tready = (r_count != CNT_W'(DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_req_valid   = (r_count != '0);
    assign pop           = i_req_pop && o_req_valid;
    assign o_req         = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_req;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/fnpll_div.sv */
module fnpll_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fnpll_pkg::t_div_cmd   i_cmd,
    output fnpll_pkg::t_div_rsp   o_rsp
);
    import fnpll_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_num;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_num[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_num <= i_cmd.dividend;
            r_rem <= '0;
            r_dvs <= i_cmd.divisor;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[DVD_W-2:0], fits};
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        end
    end

    // iteration count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1)) && !i_cmd.start;
            if (i_cmd.start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

endmodule

/* sv/fnpll_back.sv */
module fnpll_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  fnpll_pkg::t_req                i_req,
    output logic                           o_req_pop,
    input  logic [fnpll_pkg::REF_W-1:0]    i_ref_freq,
    input  logic [fnpll_pkg::STEP_W-1:0]   i_ch_step,
    output fnpll_pkg::t_div_cmd            o_div_cmd,
    input  fnpll_pkg::t_div_rsp            i_div_rsp,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fnpll_pkg::WORD_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);
    import fnpll_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEL  = 3'd1;
    localparam logic [2:0] ST_INT  = 3'd2;
    localparam logic [2:0] ST_FRAC = 3'd3;
    localparam logic [2:0] ST_MOD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [2:0] IDX_R5 = 3'd0;
    localparam logic [2:0] IDX_R4 = 3'd1;
    localparam logic [2:0] IDX_R3 = 3'd2;
    localparam logic [2:0] IDX_R2 = 3'd3;
    localparam logic [2:0] IDX_R1 = 3'd4;
    localparam logic [2:0] IDX_R0 = 3'd5;

    logic [2:0]         r_state;
    logic               r_issued;
    logic [FREQ_W-1:0]  r_freq;
    logic               r_rf_en;
    logic [SEL_W-1:0]   r_sel;
    logic [VCO_W-1:0]   r_vco;
    logic [SSTEP_W-1:0] r_sstep;
    logic [16:0]        r_integ;
    logic [REF_W-1:0]   r_rem_ref;
    logic [REF_W-1:0]   r_frac;
    logic [REF_W-1:0]   r_mod;
    logic [2:0]         r_widx;
    logic               r_tvalid;
    logic [WORD_W-1:0]  r_tdata;
    logic               r_tlast;

    logic [STEP_W-1:0]  step_eff;
    logic [SEL_W-1:0]   sel_new;
    logic               ref_nz;
    logic               out_load;
    logic [WORD_W-1:0]  word;

    assign step_eff = (i_ch_step == '0) ? STEP_DEFAULT : i_ch_step;
    assign sel_new  = top_bit_of_byte(i_div_rsp.quot[7:0]);
    assign ref_nz   = (i_ref_freq != '0);
    assign out_load = !r_tvalid || m_axis_tready;

    assign o_req_pop = (r_state == ST_IDLE) && i_req_valid;

    // divider operand select
    always_comb begin
        o_div_cmd.start    = 1'b0;
        o_div_cmd.dividend = '0;
        o_div_cmd.divisor  = '0;
        unique case (r_state)
            ST_SEL: begin
                o_div_cmd.start    = !r_issued;
                o_div_cmd.dividend = VCO_TOP_KHZ;
                o_div_cmd.divisor  = r_freq;
            end
            ST_INT: begin
                o_div_cmd.start    = !r_issued;
                o_div_cmd.dividend = r_vco;
                o_div_cmd.divisor  = DVS_W'(i_ref_freq);
            end
            ST_FRAC: begin
                o_div_cmd.start    = !r_issued;
                o_div_cmd.dividend = DVD_W'(r_rem_ref);
                o_div_cmd.divisor  = DVS_W'(r_sstep);
            end
            ST_MOD: begin
                o_div_cmd.start    = !r_issued;
                o_div_cmd.dividend = DVD_W'(i_ref_freq);
                o_div_cmd.divisor  = DVS_W'(r_sstep);
            end
            default: begin
                o_div_cmd.start = 1'b0;
            end
        endcase
    end

    // register word build, zero reference clears the divided fields
    always_comb begin
        unique case (r_widx)
            IDX_R5: word = WORD_R5;
            IDX_R4: word = (WORD_W'(r_sel) << 20) | WORD_R4_BASE
                           | (WORD_W'(r_rf_en) << 5);
            IDX_R3: word = WORD_R3;
            IDX_R2: word = WORD_R2;
            IDX_R1: word = ((ref_nz ? WORD_W'(r_mod) : '0) << 3) | WORD_R1_BASE;
            IDX_R0: word = ref_nz ? ((WORD_W'(r_frac) << 3) | (WORD_W'(r_integ) << 15))
                                  : '0;
            default: word = '0;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req_valid) begin
            r_freq  <= i_req.freq;
            r_rf_en <= i_req.rf_en;
            r_sel   <= '0;
            r_vco   <= '0;
            r_sstep <= SSTEP_W'(step_eff);
        end
        if (r_state == ST_SEL && i_div_rsp.done) begin
            r_sel   <= sel_new;
            r_vco   <= VCO_W'(r_freq) << sel_new;
            r_sstep <= SSTEP_W'(step_eff) << sel_new;
        end
        if (r_state == ST_INT && i_div_rsp.done) begin
            r_integ   <= i_div_rsp.quot[16:0];
            r_rem_ref <= i_div_rsp.rem[REF_W-1:0];
        end
        if (r_state == ST_FRAC && i_div_rsp.done) begin
            r_frac <= i_div_rsp.quot[REF_W-1:0];
        end
        if (r_state == ST_MOD && i_div_rsp.done) begin
            r_mod <= i_div_rsp.quot[REF_W-1:0];
        end
        if (r_state == ST_EMIT && out_load) begin
            r_tdata <= word;
            r_tlast <= (r_widx == IDX_R0);
        end
    end

    // sequencer and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_widx   <= IDX_R5;
            r_tvalid <= 1'b0;
        end else begin
            // output word register
            if (r_state == ST_EMIT && out_load) begin
                r_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_tvalid <= 1'b0;
            end
            if (o_div_cmd.start) begin
                r_issued <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= (i_req.freq == '0) ? ST_INT : ST_SEL;
                    end
                end
                ST_SEL: begin
                    if (i_div_rsp.done) begin
                        r_issued <= 1'b0;
                        r_state  <= ST_INT;
                    end
                end
                ST_INT: begin
                    if (i_div_rsp.done) begin
                        r_issued <= 1'b0;
                        r_state  <= ST_FRAC;
                    end
                end
                ST_FRAC: begin
                    if (i_div_rsp.done) begin
                        r_issued <= 1'b0;
                        r_state  <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (i_div_rsp.done) begin
                        r_issued <= 1'b0;
                        r_widx   <= IDX_R5;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_widx <= r_widx + 1'b1;
                        if (r_widx == IDX_R0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

endmodule

/* sv/frac_n_pll_register_words_unit.sv */
// channel | dir | handshake       | payload
// s_axis  | in  | tvalid / tready | tdata: center_freq, rf_enable; tuser: use_external
// m_axis  | out | tvalid / tready | tdata: reg_word; tlast: last_word
// cfg     | in  | i_cfg_we        | i_cfg_idx, i_cfg_data
//
// one request runs the sequencer through a pop, four passes of the shared serial
// divider (divider select, integer, fraction, modulus) and six output words; a zero
// frequency skips the divider-select pass
// requests queue ahead of the divider, so s_axis keeps accepting until the queue is full while words drain
// m_axis stalls hold the sequencer in the word phase; nothing is dropped
// i_rst_n is synchronous, active low; configuration returns to ref 10000, step 25
module frac_n_pll_register_words_unit #(
    parameter int QUEUE_DEPTH = fnpll_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [22:0] center_freq, [23] rf_enable
    input  logic [23:0]                       s_axis_tdata,
    // [0] use_external
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] reg_word
    output logic [fnpll_pkg::WORD_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [fnpll_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fnpll_pkg::CFG_W-1:0]       i_cfg_data
);
    import fnpll_pkg::*;

    logic [REF_W-1:0]  r_ref_freq;
    logic [STEP_W-1:0] r_ch_step;
    logic              req_valid;
    t_req              req;
    logic              req_pop;
    t_div_cmd          div_cmd;
    t_div_rsp          div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq <= REF_RESET;
            r_ch_step  <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REF_FREQ: r_ref_freq <= i_cfg_data[REF_W-1:0];
                REG_CH_STEP:  r_ch_step  <= i_cfg_data[STEP_W-1:0];
                default:      r_ch_step  <= r_ch_step;
            endcase
        end
    end

    fnpll_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .i_center_freq  (s_axis_tdata[FREQ_W-1:0]),
        .i_rf_enable    (s_axis_tdata[FREQ_W]),
        .i_use_external (s_axis_tuser[0]),
        .o_req_valid    (req_valid),
        .o_req          (req),
        .i_req_pop      (req_pop)
    );

    fnpll_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    fnpll_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_req_pop     (req_pop),
        .i_ref_freq    (r_ref_freq),
        .i_ch_step     (r_ch_step),
        .o_div_cmd     (div_cmd),
        .i_div_rsp     (div_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
